// ----- hw/rtl/sef_pkg.sv -----
// shared widths, register indexes and rounding helper for the spin field pipeline
`default_nettype none
package sef_pkg;

   localparam int COEF_WIDTH_DEF = 16;
   localparam int OUT_WIDTH_DEF  = 32;

   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] REG_ZEEMAN = 3'd0;
   localparam logic [IDX_W-1:0] REG_TORQUE = 3'd1;
   localparam logic [IDX_W-1:0] REG_UNIAX  = 3'd2;
   localparam logic [IDX_W-1:0] REG_AXIS_A = 3'd3;
   localparam logic [IDX_W-1:0] REG_AXIS_B = 3'd4;
   localparam logic [IDX_W-1:0] REG_AXIS_C = 3'd5;
   localparam logic [IDX_W-1:0] REG_GAINS  = 3'd6;

   // internal widths, sized from the worst case over all 16-bit inputs
   localparam int P_W    = 20;
   localparam int P2_W   = 24;
   localparam int PP_W   = 31;
   localparam int F4_W   = 30;
   localparam int F6_W   = 36;
   localparam int S4_W   = 34;
   localparam int S6_W   = 40;
   localparam int ZT_W   = 27;
   localparam int GD_W   = 36;
   localparam int UNI_W  = 32;
   localparam int BASE_W = 34;
   localparam int T4_W   = 44;
   localparam int T6_W   = 48;
   localparam int ACC_W  = 52;

   typedef logic signed [15:0]      q16_type;
   typedef logic signed [P_W-1:0]   proj_type;
   typedef logic signed [S4_W-1:0]  sum4_type;
   typedef logic signed [S6_W-1:0]  sum6_type;
   typedef logic signed [ZT_W-1:0]  zt_type;

   // round half up: floor((v + 2^(k-1)) / 2^k)
   function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                              input int unsigned k);
      rnd = (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sef_linear.sv -----
// first stage: zeeman, spin-transfer cross product and axis projections
`default_nettype none
module sef_linear (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire sef_pkg::q16_type spin [3],
   input  wire logic [15:0]      magnitude,
   input  wire sef_pkg::q16_type zee_coef [3],
   input  wire sef_pkg::q16_type trq_coef [3],
   input  wire sef_pkg::q16_type uni_axis [3],
   input  wire sef_pkg::q16_type cub_axis [3][3],
   output sef_pkg::zt_type       zee_ff [3],
   output sef_pkg::zt_type       trq_ff [3],
   output sef_pkg::proj_type     d_ff,
   output sef_pkg::proj_type     p_ff [3]
);
   import sef_pkg::*;

   logic signed [32:0] zp [3];
   logic signed [31:0] cp [6];
   logic signed [32:0] cr [3];
   logic signed [33:0] dot [4];
   zt_type             zee_in [3];
   zt_type             trq_in [3];
   proj_type           d_in;
   proj_type           p_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         zp[i] = zee_coef[i] * signed'({1'b0, magnitude});
      end
      cp[0] = spin[1] * trq_coef[2];
      cp[1] = spin[2] * trq_coef[1];
      cp[2] = spin[2] * trq_coef[0];
      cp[3] = spin[0] * trq_coef[2];
      cp[4] = spin[0] * trq_coef[1];
      cp[5] = spin[1] * trq_coef[0];
      cr[0] = cp[0] - cp[1];
      cr[1] = cp[2] - cp[3];
      cr[2] = cp[4] - cp[5];
      dot[0] = uni_axis[0] * spin[0] + uni_axis[1] * spin[1] + uni_axis[2] * spin[2];
      for (int k = 0; k < 3; k++) begin
         dot[k + 1] = cub_axis[k][0] * spin[0] + cub_axis[k][1] * spin[1]
                    + cub_axis[k][2] * spin[2];
      end
      for (int i = 0; i < 3; i++) begin
         zee_in[i] = ZT_W'(rnd(zp[i], 7));
         trq_in[i] = ZT_W'(rnd(cr[i], 9));
         p_in[i]   = P_W'(rnd(dot[i + 1], 14));
      end
      d_in = P_W'(rnd(dot[0], 14));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zee_ff <= zee_in;
         trq_ff <= trq_in;
         d_ff   <= d_in;
         p_ff   <= p_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/sef_cubic.sv -----
// cubic anisotropy: squares, fourth and sixth order factors, back-projection
`default_nettype none
module sef_cubic (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire sef_pkg::proj_type p_in [3],
   input  wire sef_pkg::q16_type  cub_axis [3][3],
   output sef_pkg::sum4_type      sum4_ff [3],
   output sef_pkg::sum6_type      sum6_ff [3]
);
   import sef_pkg::*;

   // stage 2
   logic signed [39:0]     sq [3];
   logic signed [P2_W-1:0] p2_in [3];
   logic signed [P2_W-1:0] p2_ff [3];
   proj_type               p_s2_ff [3];
   // stage 3
   logic signed [P2_W:0]   p2s [3];
   logic signed [47:0]     f4p [3];
   logic signed [47:0]     ppp [3];
   logic signed [F4_W-1:0] f4_in [3];
   logic signed [F4_W-1:0] f4_ff [3];
   logic signed [PP_W-1:0] pp_in [3];
   logic signed [PP_W-1:0] pp_ff [3];
   proj_type               p_s3_ff [3];
   // stage 4
   logic signed [52:0]     f6p [3];
   logic signed [F6_W-1:0] f6_in [3];
   logic signed [F6_W-1:0] f6_ff [3];
   logic signed [F4_W-1:0] f4_s4_ff [3];
   // stage 5
   logic signed [47:0]     acc4 [3];
   logic signed [53:0]     acc6 [3];
   sum4_type               sum4_in [3];
   sum6_type               sum6_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq[k]    = p_in[k] * p_in[k];
         p2_in[k] = P2_W'(rnd(sq[k], 14));
      end
   end

   // factor 2 folded into the rounding shift
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p2s[k]   = p2_ff[(k + 1) % 3] + p2_ff[(k + 2) % 3];
         f4p[k]   = p_s2_ff[k] * p2s[k];
         ppp[k]   = p2_ff[(k + 1) % 3] * p2_ff[(k + 2) % 3];
         f4_in[k] = F4_W'(rnd(f4p[k], 13));
         pp_in[k] = PP_W'(rnd(ppp[k], 14));
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         f6p[k]   = p_s3_ff[k] * pp_ff[k];
         f6_in[k] = F6_W'(rnd(f6p[k], 13));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc4[i] = cub_axis[0][i] * f4_s4_ff[0] + cub_axis[1][i] * f4_s4_ff[1]
                 + cub_axis[2][i] * f4_s4_ff[2];
         acc6[i] = cub_axis[0][i] * f6_ff[0] + cub_axis[1][i] * f6_ff[1]
                 + cub_axis[2][i] * f6_ff[2];
         sum4_in[i] = S4_W'(rnd(acc4[i], 14));
         sum6_in[i] = S6_W'(rnd(acc6[i], 14));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff    <= p2_in;
         p_s2_ff  <= p_in;
         f4_ff    <= f4_in;
         pp_ff    <= pp_in;
         p_s3_ff  <= p_s2_ff;
         f6_ff    <= f6_in;
         f4_s4_ff <= f4_ff;
         sum4_ff  <= sum4_in;
         sum6_ff  <= sum6_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/spin_effective_field.sv -----
// Spin precession field pipeline.
// Input channel req_*: one word per atom (group flag, Q1.14 spin, Q4.12
// magnitude). Result channel rsp_*: one word per input, the summed Q15.16
// field x, y, z and a flag set when any component saturated.
// Configuration: csr_we writes csr_wdata into the register at csr_index
// (0 zeeman, 1 torque, 2 uniaxial axis and gain, 3..5 cubic axes, 6 cubic
// gains); indexes past the list are ignored. Write only while idle.
// A word passes through seven register stages before rsp_valid rises, and one
// word can enter every cycle while the pipeline is not held; the stages each
// hold about one multiplier level:
// projections, squares, cubic factors, sixth order factor, back-projection,
// gain scaling, then sum and saturation into the output register.
// Reset clears the pipeline valid bits and all configuration registers.
// When rsp_ready is low with a word waiting, the whole pipeline holds and
// req_ready drops; nothing is lost or repeated, and bubbles drain freely.
// Atoms outside the group return an all-zero word.
`default_nettype none
module spin_effective_field #(
   parameter int COEF_WIDTH = sef_pkg::COEF_WIDTH_DEF,
   parameter int OUT_WIDTH  = sef_pkg::OUT_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_in_group,
   input  wire logic signed [15:0]      req_spin_x,
   input  wire logic signed [15:0]      req_spin_y,
   input  wire logic signed [15:0]      req_spin_z,
   input  wire logic [15:0]             req_spin_magnitude,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [31:0]           rsp_field_x,
   output logic signed [31:0]           rsp_field_y,
   output logic signed [31:0]           rsp_field_z,
   output logic                         rsp_clipped,
   input  wire logic                    csr_we,
   input  wire logic [sef_pkg::IDX_W-1:0] csr_index,
   input  wire logic [63:0]             csr_wdata
);
   import sef_pkg::*;

   localparam int CWE   = (COEF_WIDTH < 16) ? COEF_WIDTH : 16;
   localparam int OW    = (OUT_WIDTH < 32) ? OUT_WIDTH : 32;
   localparam logic signed [ACC_W-1:0] LIM_HI = (ACC_W'(1) <<< (OW - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - ACC_W'(1);
   localparam int NSTG  = 7;

   function automatic q16_type coef(input logic [15:0] slot);
      coef = signed'(16'(slot << (16 - CWE))) >>> (16 - CWE);
   endfunction

   logic [47:0] zeeman_ff, torque_ff, axis_a_ff, axis_b_ff, axis_c_ff;
   logic [63:0] uniax_ff;
   logic [31:0] gains_ff;

   logic            en;
   logic [NSTG:1]   vld_ff;
   logic [NSTG-1:1] grp_ff;

   q16_type spin [3];
   q16_type zee_coef [3];
   q16_type trq_coef [3];
   q16_type uni_axis [3];
   q16_type cub_axis [3][3];
   q16_type gain_u, gain_k4, gain_k6;

   zt_type   zee_s1 [3];
   zt_type   trq_s1 [3];
   proj_type d_s1;
   proj_type p_s1 [3];
   sum4_type sum4_s5 [3];
   sum6_type sum6_s5 [3];

   logic signed [ZT_W:0]     zt_in [3];
   logic signed [ZT_W:0]     zt_ff [3];
   logic signed [ZT_W:0]     zt_s3_ff [3];
   logic signed [GD_W-1:0]   gd_in, gd_ff;
   logic signed [51:0]       unip [3];
   logic signed [UNI_W-1:0]  uni_in [3];
   logic signed [UNI_W-1:0]  uni_ff [3];
   logic signed [BASE_W-1:0] base_in [3];
   logic signed [BASE_W-1:0] base_s4_ff [3];
   logic signed [BASE_W-1:0] base_s5_ff [3];
   logic signed [BASE_W-1:0] base_s6_ff [3];
   logic signed [49:0]       t4p [3];
   logic signed [55:0]       t6p [3];
   logic signed [T4_W-1:0]   t4_in [3];
   logic signed [T4_W-1:0]   t4_ff [3];
   logic signed [T6_W-1:0]   t6_in [3];
   logic signed [T6_W-1:0]   t6_ff [3];
   logic signed [ACC_W-1:0]  acc [3];
   logic signed [31:0]       fld_in [3];
   logic signed [31:0]       fld_ff [3];
   logic [2:0]               sat;
   logic                     clip_in, clip_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         zeeman_ff <= '0;
         torque_ff <= '0;
         uniax_ff  <= '0;
         axis_a_ff <= '0;
         axis_b_ff <= '0;
         axis_c_ff <= '0;
         gains_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ZEEMAN: zeeman_ff <= csr_wdata[47:0];
            REG_TORQUE: torque_ff <= csr_wdata[47:0];
            REG_UNIAX:  uniax_ff  <= csr_wdata;
            REG_AXIS_A: axis_a_ff <= csr_wdata[47:0];
            REG_AXIS_B: axis_b_ff <= csr_wdata[47:0];
            REG_AXIS_C: axis_c_ff <= csr_wdata[47:0];
            REG_GAINS:  gains_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      spin[0] = req_spin_x;
      spin[1] = req_spin_y;
      spin[2] = req_spin_z;
      for (int i = 0; i < 3; i++) begin
         zee_coef[i]    = coef(zeeman_ff[16*i +: 16]);
         trq_coef[i]    = coef(torque_ff[16*i +: 16]);
         uni_axis[i]    = uniax_ff[16*i +: 16];
         cub_axis[0][i] = axis_a_ff[16*i +: 16];
         cub_axis[1][i] = axis_b_ff[16*i +: 16];
         cub_axis[2][i] = axis_c_ff[16*i +: 16];
      end
      gain_u  = coef(uniax_ff[63:48]);
      gain_k4 = coef(gains_ff[15:0]);
      gain_k6 = coef(gains_ff[31:16]);
   end

   // whole pipeline advances unless a finished word is waiting and rsp_ready is low
   assign en        = !vld_ff[NSTG] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[NSTG];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         grp_ff <= {grp_ff[NSTG-2:1], req_in_group};
      end
   end

   sef_linear u_linear (
      .clock     (clock),
      .en        (en),
      .spin      (spin),
      .magnitude (req_spin_magnitude),
      .zee_coef  (zee_coef),
      .trq_coef  (trq_coef),
      .uni_axis  (uni_axis),
      .cub_axis  (cub_axis),
      .zee_ff    (zee_s1),
      .trq_ff    (trq_s1),
      .d_ff      (d_s1),
      .p_ff      (p_s1)
   );

   sef_cubic u_cubic (
      .clock    (clock),
      .en       (en),
      .p_in     (p_s1),
      .cub_axis (cub_axis),
      .sum4_ff  (sum4_s5),
      .sum6_ff  (sum6_s5)
   );

   // uniaxial path, linear terms and cubic gain scaling, aligned with the cubic stages
   always_comb begin
      gd_in = gain_u * d_s1;
      for (int i = 0; i < 3; i++) begin
         zt_in[i]   = zee_s1[i] + trq_s1[i];
         unip[i]    = gd_ff * uni_axis[i];
         uni_in[i]  = UNI_W'(rnd(unip[i], 22));
         base_in[i] = zt_s3_ff[i] + uni_ff[i];
         t4p[i]     = gain_k4 * sum4_s5[i];
         t6p[i]     = gain_k6 * sum6_s5[i];
         t4_in[i]   = T4_W'(rnd(t4p[i], 9));
         t6_in[i]   = T6_W'(rnd(t6p[i], 9));
      end
   end

   // final sum and saturation
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = base_s6_ff[i] + t4_ff[i] + t6_ff[i];
         sat[i] = 1'b1;
         if (acc[i] > LIM_HI) begin
            fld_in[i] = 32'(LIM_HI);
         end else if (acc[i] < LIM_LO) begin
            fld_in[i] = 32'(LIM_LO);
         end else begin
            fld_in[i] = 32'(acc[i]);
            sat[i]    = 1'b0;
         end
         if (!grp_ff[NSTG-1]) begin
            fld_in[i] = '0;
         end
      end
      clip_in = grp_ff[NSTG-1] && (sat != 3'b000);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zt_ff      <= zt_in;
         gd_ff      <= gd_in;
         zt_s3_ff   <= zt_ff;
         uni_ff     <= uni_in;
         base_s4_ff <= base_in;
         base_s5_ff <= base_s4_ff;
         base_s6_ff <= base_s5_ff;
         t4_ff      <= t4_in;
         t6_ff      <= t6_in;
         fld_ff     <= fld_in;
         clip_ff    <= clip_in;
      end
   end

   assign rsp_field_x = fld_ff[0];
   assign rsp_field_y = fld_ff[1];
   assign rsp_field_z = fld_ff[2];
   assign rsp_clipped = clip_ff;

endmodule
`default_nettype wire
